### sv/mcm_pkg.sv
package mcm_pkg;

  localparam int ELEM_W    = 32;
  localparam int NUM_LANES = 4;
  localparam int LANE_W    = 2;
  localparam int PROD_W    = 2 * ELEM_W;
  // four full products need two guard bits
  localparam int ACC_W     = PROD_W + 2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MUL  = 1'b1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              load_we;   // write one column of the left matrix
    logic              start;     // capture right column, clear sums
    logic              mul_en;    // register the products of one term
    logic              acc_en;    // add registered products into the sums
    logic              out_load;  // round, saturate and fill output register
    logic [LANE_W-1:0] term;      // which term k is being multiplied
  } cmd_t;

endpackage

### sv/mcm_ctrl.sv
module mcm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          mode_i,
  input  logic          out_stall_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output mcm_pkg::cmd_t cmd_o
);

  mcm_pkg::state_e                   state_q, state_d;
  logic [mcm_pkg::LANE_W-1:0]        term_q, term_d;
  logic                              out_valid_q, out_valid_d;
  logic                              in_take;
  logic                              out_free;

  assign in_stall_o  = (state_q != mcm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcm_pkg::ST_IDLE;
      term_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    term_d       = term_q;
    cmd_o        = '0;
    cmd_o.term   = term_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      mcm_pkg::ST_IDLE: begin
        if (in_take) begin
          if (mode_i == mcm_pkg::MODE_MUL) begin
            cmd_o.start = 1'b1;
            term_d      = '0;
            state_d     = mcm_pkg::ST_MUL;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      mcm_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        // the products registered for the previous term are added; the first term has none
        cmd_o.acc_en = (term_q != '0);
        term_d       = term_q + 1'b1;
        if (term_q == mcm_pkg::LANE_W'(mcm_pkg::NUM_LANES - 1)) begin
          state_d = mcm_pkg::ST_ACC;
        end
      end
      mcm_pkg::ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = mcm_pkg::ST_FIN;
      end
      mcm_pkg::ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = mcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/mcm_dpath.sv
module mcm_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  mcm_pkg::cmd_t              cmd_i,
  input  logic [mcm_pkg::LANE_W-1:0] column_i,
  input  mcm_pkg::elem_t             elem_x_i,
  input  mcm_pkg::elem_t             elem_y_i,
  input  mcm_pkg::elem_t             elem_z_i,
  input  mcm_pkg::elem_t             elem_w_i,
  output logic [mcm_pkg::LANE_W-1:0] out_column_o,
  output mcm_pkg::elem_t             out_x_o,
  output mcm_pkg::elem_t             out_y_o,
  output mcm_pkg::elem_t             out_z_o,
  output mcm_pkg::elem_t             out_w_o,
  output logic                       overflow_o
);

  localparam int N = mcm_pkg::NUM_LANES;
  localparam int FRAC_NZ = (FRAC_BITS != 0) ? 1 : 0;
  localparam mcm_pkg::acc_t HALF =
    mcm_pkg::acc_t'(FRAC_NZ) <<< (FRAC_BITS - FRAC_NZ);
  localparam mcm_pkg::elem_t SAT_MAX = {1'b0, {(mcm_pkg::ELEM_W-1){1'b1}}};
  localparam mcm_pkg::elem_t SAT_MIN = {1'b1, {(mcm_pkg::ELEM_W-1){1'b0}}};

  // left matrix, indexed [column][row]
  mcm_pkg::elem_t             mat_q [N][N];
  mcm_pkg::elem_t             in_elem [N];
  mcm_pkg::elem_t             rcol_q [N];
  mcm_pkg::prod_t             prod_q [N];
  mcm_pkg::acc_t              acc_q [N];
  mcm_pkg::elem_t             res [N];
  logic [N-1:0]               sat;
  logic [mcm_pkg::LANE_W-1:0] col_q;
  mcm_pkg::elem_t             out_q [N];
  logic [mcm_pkg::LANE_W-1:0] out_col_q;
  logic                       ovf_q;

  assign in_elem[0] = elem_x_i;
  assign in_elem[1] = elem_y_i;
  assign in_elem[2] = elem_z_i;
  assign in_elem[3] = elem_w_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      for (int r = 0; r < N; r++) begin
        mat_q[column_i][r] <= in_elem[r];
      end
    end
    if (cmd_i.start) begin
      col_q <= column_i;
      for (int r = 0; r < N; r++) begin
        rcol_q[r] <= in_elem[r];
      end
    end
  end

  // one term per cycle: four row multipliers, then accumulate
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < N; r++) begin
      if (cmd_i.mul_en) begin
        prod_q[r] <= mat_q[cmd_i.term][r] * rcol_q[cmd_i.term];
      end
      if (cmd_i.start) begin
        acc_q[r] <= '0;
      end else if (cmd_i.acc_en) begin
        acc_q[r] <= acc_q[r] + mcm_pkg::acc_t'(prod_q[r]);
      end
    end
  end

  // round to nearest with ties up, shift, saturate
  always_comb begin
    mcm_pkg::acc_t rnd;
    for (int r = 0; r < N; r++) begin
      rnd = (acc_q[r] + HALF) >>> FRAC_BITS;
      if (rnd[mcm_pkg::ACC_W-1:mcm_pkg::ELEM_W-1] == '0 ||
          rnd[mcm_pkg::ACC_W-1:mcm_pkg::ELEM_W-1] == '1) begin
        res[r] = rnd[mcm_pkg::ELEM_W-1:0];
        sat[r] = 1'b0;
      end else begin
        res[r] = rnd[mcm_pkg::ACC_W-1] ? SAT_MIN : SAT_MAX;
        sat[r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int r = 0; r < N; r++) begin
        out_q[r] <= res[r];
      end
      out_col_q <= col_q;
      ovf_q     <= |sat;
    end
  end

  assign out_column_o = out_col_q;
  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign out_w_o      = out_q[3];
  assign overflow_o   = ovf_q;

endmodule

### sv/mat4_column_multiply_unit.sv
// 4x4 column-major matrix product D * R in signed fixed point (FRAC_BITS
// fraction bits, Q16.16 by default).
// input channel (in_valid_i / in_stall_o): mode_i = 0 loads column column_i
// of D from elem_x_i..elem_w_i and gives no result; mode_i = 1 multiplies D
// by the right column elem_x_i..elem_w_i and gives one result transaction.
// output channel (out_valid_o / out_stall_i): result column out_x_o..out_w_o,
// each row sum rounded to nearest (ties up) and saturated to 32 bits;
// overflow_o flags that at least one row saturated in this transaction.
// loads may follow each other every cycle.
// a multiply runs four terms through four row multipliers, one term per
// cycle, then adds the last products in ST_ACC and rounds into the output
// register in ST_FIN; in_stall_o is high after acceptance until the unit is
// back in ST_IDLE, so the next transaction waits until the result is loaded.
// a finished result waits in the output register while out_stall_i is high;
// the rounding stage holds its result until that register is free, and
// in_stall_o stays high meanwhile.
// reset clears the control state and the output valid; D is not cleared and
// must be loaded before a multiply reads it.
module mat4_column_multiply_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [mcm_pkg::LANE_W-1:0] column_i,
  input  mcm_pkg::elem_t             elem_x_i,
  input  mcm_pkg::elem_t             elem_y_i,
  input  mcm_pkg::elem_t             elem_z_i,
  input  mcm_pkg::elem_t             elem_w_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mcm_pkg::LANE_W-1:0] out_column_o,
  output mcm_pkg::elem_t             out_x_o,
  output mcm_pkg::elem_t             out_y_o,
  output mcm_pkg::elem_t             out_z_o,
  output mcm_pkg::elem_t             out_w_o,
  output logic                       overflow_o
);

  mcm_pkg::cmd_t cmd;

  mcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  mcm_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .column_i     (column_i),
    .elem_x_i     (elem_x_i),
    .elem_y_i     (elem_y_i),
    .elem_z_i     (elem_z_i),
    .elem_w_i     (elem_w_i),
    .out_column_o (out_column_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_w_o      (out_w_o),
    .overflow_o   (overflow_o)
  );

endmodule

### sv/mcm_checker.sv
module mcm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic mode_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic overflow_o
);

  logic mul_take;
  logic load_take;

  assign mul_take  = in_valid_i && !in_stall_o && (mode_i == mcm_pkg::MODE_MUL);
  assign load_take = in_valid_i && !in_stall_o && (mode_i == mcm_pkg::MODE_LOAD);

  // a stalled result stays offered with its flag unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(overflow_o))
    else $error("stalled result dropped or changed");

  // a multiply keeps the input side busy in the following cycle
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_take |=> in_stall_o)
    else $error("input taken right after a multiply");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_take && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a load");

  // a new result must come from a multiply that was taken earlier
  a_mul_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(mul_take, 7))
    else $error("result without matching multiply");

endmodule

bind mat4_column_multiply_unit mcm_checker u_mcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .overflow_o  (overflow_o)
);
